>>> design/base64_stream_decoder_macros.svh
// Assertion macros for the Base64 stream decoder RTL
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low
`define B64SD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64sd assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low
`define B64SD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64sd assertion failed");
`else
`define B64SD_ASSERT_NOW(label, ante, cons)
`define B64SD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/b64sd_pkg.sv
// Types, constants and the character map of the Base64 stream decoder
package b64sd_pkg;

    localparam int CHAR_W   = 8;
    localparam int BYTE_W   = 8;
    localparam int SEXTET_W = 6;
    localparam int COUNT_W  = 2;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_PAD     = 8'h3D;

    localparam logic [CHAR_W-1:0]   LOWER_BASE  = 8'd26;
    localparam logic [CHAR_W-1:0]   DIGIT_BASE  = 8'd52;
    localparam logic [SEXTET_W-1:0] VALUE_PLUS  = 6'd62;
    localparam logic [SEXTET_W-1:0] VALUE_SLASH = 6'd63;

    localparam logic [COUNT_W-1:0] COUNT_NONE  = 2'd0;
    localparam logic [COUNT_W-1:0] COUNT_ONE   = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_TWO   = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_THREE = 2'd3;

    // Position of the next counted character within its group of four
    typedef enum logic [1:0] {
        SLOT_A,
        SLOT_B,
        SLOT_C,
        SLOT_D
    } b64sd_slot_t;

    typedef struct packed {
        logic                hit;
        logic [SEXTET_W-1:0] value;
    } b64sd_sextet_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  byte_first;
        logic [BYTE_W-1:0]  byte_second;
        logic [BYTE_W-1:0]  byte_third;
        logic [COUNT_W-1:0] byte_count;
        logic               end_flag;
    } b64sd_result_t;

    function automatic b64sd_sextet_t sextet_of(input logic [CHAR_W-1:0] ch);
        b64sd_sextet_t      res;
        logic [CHAR_W-1:0]  diff;
        res  = '0;
        diff = '0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
        begin
            diff      = CHAR_W'(ch - CHAR_UPPER_A);
            res.hit   = 1'b1;
            res.value = diff[SEXTET_W-1:0];
        end
        else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
        begin
            diff      = CHAR_W'(ch - CHAR_LOWER_A + LOWER_BASE);
            res.hit   = 1'b1;
            res.value = diff[SEXTET_W-1:0];
        end
        else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9)
        begin
            diff      = CHAR_W'(ch - CHAR_DIGIT_0 + DIGIT_BASE);
            res.hit   = 1'b1;
            res.value = diff[SEXTET_W-1:0];
        end
        else if (ch == CHAR_PLUS)
        begin
            res.hit   = 1'b1;
            res.value = VALUE_PLUS;
        end
        else if (ch == CHAR_SLASH)
        begin
            res.hit   = 1'b1;
            res.value = VALUE_SLASH;
        end
        return res;
    endfunction

endpackage

>>> design/b64sd_char_if.sv
// Character channel: one Base64 text character per transfer
interface b64sd_char_if;
    import b64sd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              msg_end;

    modport source (output valid, output char_in, output msg_end, input ready);
    modport sink (input valid, input char_in, input msg_end, output ready);
endinterface

>>> design/b64sd_byte_if.sv
// Result channel: up to three decoded bytes per transfer
interface b64sd_byte_if;
    import b64sd_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  byte_first;
    logic [BYTE_W-1:0]  byte_second;
    logic [BYTE_W-1:0]  byte_third;
    logic [COUNT_W-1:0] byte_count;
    logic               end_flag;

    modport source (
        output valid, output byte_first, output byte_second, output byte_third,
        output byte_count, output end_flag, input ready
    );
    modport sink (
        input valid, input byte_first, input byte_second, input byte_third,
        input byte_count, input end_flag, output ready
    );
endinterface

>>> design/b64sd_group.sv
// Group state and decode: collects sextets and assembles the bytes of a group
`include "base64_stream_decoder_macros.svh"

module b64sd_group (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               char_in,
    input  logic                     msg_end,
    output b64sd_pkg::b64sd_result_t result,
    output logic                     emit
);
    import b64sd_pkg::*;

    b64sd_slot_t         slot_reg, slot_next;
    logic [SEXTET_W-1:0] sextet_a_reg, sextet_a_next;
    logic [SEXTET_W-1:0] sextet_b_reg, sextet_b_next;
    logic [SEXTET_W-1:0] sextet_c_reg, sextet_c_next;
    logic                group_void_reg, group_void_next;
    logic                third_pad_reg, third_pad_next;

    b64sd_sextet_t       map;
    logic                pad;
    logic                counted;
    logic                done;
    logic [SEXTET_W-1:0] val;
    logic [COUNT_W-1:0]  cnt;
    logic [BYTE_W-1:0]   b0, b1, b2;

    assign map     = sextet_of(char_in);
    assign pad     = (char_in == CHAR_PAD);
    assign counted = map.hit || pad;
    assign val     = pad ? '0 : map.value;
    assign done    = counted && (slot_reg == SLOT_D);

    always_comb
    begin
        if (group_void_reg)
            cnt = COUNT_NONE;
        else if (third_pad_reg)
            cnt = COUNT_ONE;
        else if (pad)
            cnt = COUNT_TWO;
        else
            cnt = COUNT_THREE;
    end

    // Zero every byte beyond the count
    assign b0 = (done && cnt != COUNT_NONE) ? {sextet_a_reg, sextet_b_reg[5:4]} : '0;
    assign b1 = (done && (cnt == COUNT_TWO || cnt == COUNT_THREE))
                ? {sextet_b_reg[3:0], sextet_c_reg[5:2]} : '0;
    assign b2 = (done && cnt == COUNT_THREE) ? {sextet_c_reg[1:0], val} : '0;

    assign result.byte_first  = b0;
    assign result.byte_second = b1;
    assign result.byte_third  = b2;
    assign result.byte_count  = done ? cnt : COUNT_NONE;
    assign result.end_flag    = msg_end;

    assign emit = msg_end || (done && cnt != COUNT_NONE);

    always_comb
    begin
        slot_next       = slot_reg;
        sextet_a_next   = sextet_a_reg;
        sextet_b_next   = sextet_b_reg;
        sextet_c_next   = sextet_c_reg;
        group_void_next = group_void_reg;
        third_pad_next  = third_pad_reg;
        if (step)
        begin
            if (msg_end || done)
            begin
                slot_next       = SLOT_A;
                sextet_a_next   = '0;
                sextet_b_next   = '0;
                sextet_c_next   = '0;
                group_void_next = 1'b0;
                third_pad_next  = 1'b0;
            end
            else if (counted)
            begin
                unique case (slot_reg)
                    SLOT_A:
                    begin
                        sextet_a_next   = val;
                        group_void_next = group_void_reg | pad;
                        slot_next       = SLOT_B;
                    end
                    SLOT_B:
                    begin
                        sextet_b_next   = val;
                        group_void_next = group_void_reg | pad;
                        slot_next       = SLOT_C;
                    end
                    SLOT_C:
                    begin
                        sextet_c_next  = val;
                        third_pad_next = pad;
                        slot_next      = SLOT_D;
                    end
                    SLOT_D:
                    begin
                        slot_next = SLOT_A;
                    end
                    default:
                    begin
                        slot_next = SLOT_A;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg       <= SLOT_A;
            sextet_a_reg   <= '0;
            sextet_b_reg   <= '0;
            sextet_c_reg   <= '0;
            group_void_reg <= 1'b0;
            third_pad_reg  <= 1'b0;
        end
        else
        begin
            slot_reg       <= slot_next;
            sextet_a_reg   <= sextet_a_next;
            sextet_b_reg   <= sextet_b_next;
            sextet_c_reg   <= sextet_c_next;
            group_void_reg <= group_void_next;
            third_pad_reg  <= third_pad_next;
        end
    end

    `B64SD_ASSERT_NEXT(a_end_clears_group, step && msg_end, slot_reg == SLOT_A && !group_void_reg && !third_pad_reg)
    `B64SD_ASSERT_NEXT(a_ignored_holds_slot, step && !counted && !msg_end, $stable(slot_reg))
    `B64SD_ASSERT_NOW(a_mid_result_has_bytes, emit && !msg_end, result.byte_count != COUNT_NONE)
    `B64SD_ASSERT_NOW(a_third_pad_late, third_pad_reg, slot_reg == SLOT_D)

endmodule

>>> design/base64_stream_decoder.sv
// Base64 stream decoder top level: input register, group decode, result register.
// A character passes the input register, then group decode, then the result register.
// Throughput: one character per cycle while the result side does not stall; decode is combinational.
// An output register decouples the sides; a stalled result holds decode, then the input.
// Reset (rst_n, asynchronous, active low) empties both registers and clears the group.
module base64_stream_decoder (
    input  logic                clk,
    input  logic                rst_n,
    b64sd_char_if.sink          text,
    b64sd_byte_if.source        data
);
    import b64sd_pkg::*;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              end_reg;
    logic              out_valid_reg;
    b64sd_result_t     result_reg;

    logic              advance;
    b64sd_result_t     result;
    logic              emit;

    // Decode the held character when the result register can take its output
    assign advance    = in_valid_reg && (!out_valid_reg || data.ready);
    assign text.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (text.ready)
            in_valid_reg <= text.valid;
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            char_reg <= text.char_in;
            end_reg  <= text.msg_end;
        end
    end

    b64sd_group u_group (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .char_in (char_reg),
        .msg_end (end_reg),
        .result  (result),
        .emit    (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= emit;
        else if (data.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            result_reg <= result;
    end

    assign data.valid       = out_valid_reg;
    assign data.byte_first  = result_reg.byte_first;
    assign data.byte_second = result_reg.byte_second;
    assign data.byte_third  = result_reg.byte_third;
    assign data.byte_count  = result_reg.byte_count;
    assign data.end_flag    = result_reg.end_flag;

endmodule

>>> verif/tb.sv
// Testbench for base64_stream_decoder: directed table, then random messages checked by a predictor
`timescale 1ns / 100ps

module tb;
    import b64sd_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              typed;
        b64sd_result_t     want;
    } script_row_t;

    localparam b64sd_result_t NO_RES = '0;
    localparam int            NUM_SCRIPT = 25;
    localparam int            RANDOM_CHARS = 2000;

    logic clk = 1'b0;
    logic rst_n;

    b64sd_char_if char_ch ();
    b64sd_byte_if byte_ch ();

    base64_stream_decoder u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (char_ch),
        .data  (byte_ch)
    );

    // Predictor state: the group under assembly
    b64sd_slot_t         grp_slot;
    logic [SEXTET_W-1:0] grp_a;
    logic [SEXTET_W-1:0] grp_b;
    logic [SEXTET_W-1:0] grp_c;
    logic                grp_void;
    logic                grp_pad3;

    b64sd_result_t decoded_due[$];
    int            mismatch_count = 0;
    int            results_seen   = 0;
    int            counted_chars  = 0;
    bit            idle_on        = 1'b1;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_error(input string msg);
        mismatch_count++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    function automatic bit char_value(input logic [CHAR_W-1:0] ch,
                                      output logic [SEXTET_W-1:0] val);
        val = '0;
        if (ch inside {[8'h41:8'h5A]})
        begin
            val = SEXTET_W'(ch - 8'h41);
            return 1'b1;
        end
        if (ch inside {[8'h61:8'h7A]})
        begin
            val = SEXTET_W'(ch - 8'h61 + 8'd26);
            return 1'b1;
        end
        if (ch inside {[8'h30:8'h39]})
        begin
            val = SEXTET_W'(ch - 8'h30 + 8'd52);
            return 1'b1;
        end
        if (ch == CHAR_PLUS)
        begin
            val = VALUE_PLUS;
            return 1'b1;
        end
        if (ch == CHAR_SLASH)
        begin
            val = VALUE_SLASH;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [SEXTET_W-1:0] v);
        if (v < 26)
            return CHAR_W'(8'h41 + v);
        if (v < 52)
            return CHAR_W'(8'h61 + v - 26);
        if (v < 62)
            return CHAR_W'(8'h30 + v - 52);
        return (v == VALUE_PLUS) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    // Any code the decoder must skip
    function automatic logic [CHAR_W-1:0] noise_char();
        logic [CHAR_W-1:0]   ch;
        logic [SEXTET_W-1:0] v;
        do
            ch = CHAR_W'($urandom_range(255));
        while (char_value(ch, v) || ch == CHAR_PAD);
        return ch;
    endfunction

    function automatic void clear_group();
        grp_slot = SLOT_A;
        grp_a    = '0;
        grp_b    = '0;
        grp_c    = '0;
        grp_void = 1'b0;
        grp_pad3 = 1'b0;
    endfunction

    // Advance the group by one character; returns 1 when a result is due
    function automatic bit decode_step(input logic [CHAR_W-1:0] ch, input logic last,
                                       output b64sd_result_t res);
        logic [SEXTET_W-1:0] val;
        bit                  digit;
        bit                  pad;
        bit                  done;
        res   = '0;
        done  = 1'b0;
        digit = char_value(ch, val);
        pad   = (ch == CHAR_PAD);
        if (digit || pad)
        begin
            if (pad)
                val = '0;
            case (grp_slot)
                SLOT_A:
                begin
                    grp_a    = val;
                    grp_void = grp_void | pad;
                    grp_slot = SLOT_B;
                end
                SLOT_B:
                begin
                    grp_b    = val;
                    grp_void = grp_void | pad;
                    grp_slot = SLOT_C;
                end
                SLOT_C:
                begin
                    grp_c    = val;
                    grp_pad3 = pad;
                    grp_slot = SLOT_D;
                end
                default:
                begin
                    done = 1'b1;
                    if (!grp_void)
                    begin
                        res.byte_first = {grp_a, grp_b[5:4]};
                        res.byte_count = COUNT_ONE;
                        if (!grp_pad3)
                        begin
                            res.byte_second = {grp_b[3:0], grp_c[5:2]};
                            res.byte_count  = COUNT_TWO;
                            if (!pad)
                            begin
                                res.byte_third = {grp_c[1:0], val};
                                res.byte_count = COUNT_THREE;
                            end
                        end
                    end
                    clear_group();
                end
            endcase
        end
        if (last)
            clear_group();
        res.end_flag = last;
        return last || (done && res.byte_count != COUNT_NONE);
    endfunction

    // Hold the character until the block takes it
    task automatic offer_char(input logic [CHAR_W-1:0] ch, input logic last);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 18)
        begin
            char_ch.valid <= 1'b0;
            @(negedge clk);
        end
        char_ch.valid   <= 1'b1;
        char_ch.char_in <= ch;
        char_ch.msg_end <= last;
        do
            @(posedge clk);
        while (!char_ch.ready);
    endtask

    task automatic feed_char(input logic [CHAR_W-1:0] ch, input logic last);
        b64sd_result_t       res;
        logic [SEXTET_W-1:0] v;
        offer_char(ch, last);
        if (char_value(ch, v) || ch == CHAR_PAD)
            counted_chars++;
        if (decode_step(ch, last, res))
            decoded_due.push_back(res);
    endtask

    task automatic send_message();
        int                kind;
        int                groups;
        int                pads;
        int                n;
        int                g;
        int                k;
        bit                tail;
        logic [CHAR_W-1:0] ch;
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            // Well-formed text, optional padding in the last group, stray noise between
            groups = $urandom_range(1, 5);
            pads   = $urandom_range(2);
            tail   = ($urandom_range(99) < 10);
            for (g = 0; g < groups; g++)
                for (k = 0; k < 4; k++)
                begin
                    if ($urandom_range(99) < 8)
                        feed_char(noise_char(), 1'b0);
                    if (g == groups - 1 && k >= 4 - pads)
                        ch = CHAR_PAD;
                    else
                        ch = digit_char(SEXTET_W'($urandom_range(63)));
                    feed_char(ch, g == groups - 1 && k == 3 && !tail);
                end
            if (tail)
                feed_char(noise_char(), 1'b1);
        end
        else if (kind < 90)
        begin
            // Broken text: padding anywhere, group often cut short
            n = $urandom_range(1, 15);
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(99) < 20)
                    ch = CHAR_PAD;
                else
                    ch = digit_char(SEXTET_W'($urandom_range(63)));
                feed_char(ch, k == n - 1);
            end
        end
        else
        begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++)
                feed_char(CHAR_W'($urandom_range(255)), k == n - 1);
        end
    endtask

    // Result side: random stalls, one long hold-off to back the block up
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        byte_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= 150)
            begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                byte_ch.ready <= 1'b0;
            end
            else
                byte_ch.ready <= !idle_on || ($urandom_range(99) >= 18);
        end
    end

    always @(posedge clk)
    begin
        b64sd_result_t got;
        b64sd_result_t want;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            results_seen++;
            got.byte_first  = byte_ch.byte_first;
            got.byte_second = byte_ch.byte_second;
            got.byte_third  = byte_ch.byte_third;
            got.byte_count  = byte_ch.byte_count;
            got.end_flag    = byte_ch.end_flag;
            if (decoded_due.size() == 0)
                report_error($sformatf("unexpected transfer %h %h %h cnt %0d end %0d",
                    got.byte_first, got.byte_second, got.byte_third,
                    got.byte_count, got.end_flag));
            else
            begin
                want = decoded_due.pop_front();
                if (got.byte_first != want.byte_first || got.byte_second != want.byte_second
                    || got.byte_third != want.byte_third
                    || got.byte_count != want.byte_count || got.end_flag != want.end_flag)
                    report_error($sformatf(
                        "got %h %h %h cnt %0d end %0d, want %h %h %h cnt %0d end %0d",
                        got.byte_first, got.byte_second, got.byte_third,
                        got.byte_count, got.end_flag,
                        want.byte_first, want.byte_second, want.byte_third,
                        want.byte_count, want.end_flag));
            end
        end
    end

    initial
    begin
        script_row_t   script [0:NUM_SCRIPT-1];
        b64sd_result_t res;
        int            guard;
        rst_n           = 1'b0;
        char_ch.valid   = 1'b0;
        char_ch.char_in = '0;
        char_ch.msg_end = 1'b0;
        clear_group();
        script = '{
            // all-zero group
            {"A", 1'b0, 1'b0, NO_RES},
            {"A", 1'b0, 1'b0, NO_RES},
            {"A", 1'b0, 1'b0, NO_RES},
            {"A", 1'b0, 1'b1, {8'h00, 8'h00, 8'h00, COUNT_THREE, 1'b0}},
            // all-ones group
            {"/", 1'b0, 1'b0, NO_RES},
            {"/", 1'b0, 1'b0, NO_RES},
            {"/", 1'b0, 1'b0, NO_RES},
            {"/", 1'b0, 1'b1, {8'hFF, 8'hFF, 8'hFF, COUNT_THREE, 1'b0}},
            // padding in the fourth place, unused byte reads zero
            {"Q", 1'b0, 1'b0, NO_RES},
            {"U", 1'b0, 1'b0, NO_RES},
            {"I", 1'b0, 1'b0, NO_RES},
            {CHAR_PAD, 1'b0, 1'b1, {8'h41, 8'h42, 8'h00, COUNT_TWO, 1'b0}},
            // padding in the first place voids the group, no transfer mid message
            {CHAR_PAD, 1'b0, 1'b0, NO_RES},
            {"A", 1'b0, 1'b0, NO_RES},
            {"A", 1'b0, 1'b0, NO_RES},
            {"A", 1'b0, 1'b0, NO_RES},
            // padding in the third place, group closed by the end character
            {"Q", 1'b0, 1'b0, NO_RES},
            {"Q", 1'b0, 1'b0, NO_RES},
            {CHAR_PAD, 1'b0, 1'b0, NO_RES},
            {CHAR_PAD, 1'b1, 1'b1, {8'h41, 8'h00, 8'h00, COUNT_ONE, 1'b1}},
            // skipped code inside a group that the end cuts short
            {"A", 1'b0, 1'b0, NO_RES},
            {8'h80, 1'b0, 1'b0, NO_RES},
            {"B", 1'b0, 1'b0, NO_RES},
            {"C", 1'b1, 1'b1, {8'h00, 8'h00, 8'h00, COUNT_NONE, 1'b1}},
            // skipped code carrying the end
            {8'hFF, 1'b1, 1'b1, {8'h00, 8'h00, 8'h00, COUNT_NONE, 1'b1}}
        };
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            offer_char(script[i].ch, script[i].last);
            if (decode_step(script[i].ch, script[i].last, res))
                decoded_due.push_back(script[i].typed ? script[i].want : res);
        end

        counted_chars = 0;
        while (counted_chars < RANDOM_CHARS)
        begin
            // drop idling on both sides for one stretch of the run
            idle_on = !(counted_chars >= 800 && counted_chars < 1100);
            send_message();
        end

        @(negedge clk);
        char_ch.valid <= 1'b0;
        guard = 0;
        while (decoded_due.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);
        if (decoded_due.size() != 0)
            report_error($sformatf("%0d decoded results never arrived", decoded_due.size()));
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> base64_stream_decoder.f
+incdir+design
design/b64sd_pkg.sv
design/b64sd_char_if.sv
design/b64sd_byte_if.sv
design/b64sd_group.sv
design/base64_stream_decoder.sv
verif/tb.sv
